>>> rtl/core/rc_frame_receiver_decoder_core_assert.svh
// Assertion macros shared by the RC frame receiver and decoder RTL.
`ifndef RC_FRAME_RECEIVER_DECODER_CORE_ASSERT_SVH
`define RC_FRAME_RECEIVER_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define RCFRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define RCFRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rcfrd_pkg.sv
// Package: item types, latch state type and constants of the RC frame decoder.
`default_nettype none
package rcfrd_pkg;

  // Frame layout
  localparam logic [2:0] PAYLOAD_LEN = 3'd5;

  // Thrust code that arms remote mode
  localparam logic [15:0] ARM_THRUST = 16'h8000;

  // Offset removed from the stick bytes
  localparam logic [7:0] STICK_MID = 8'h80;

  // Register reset values
  localparam logic [7:0]  START_MARKER_RST  = 8'h66;
  localparam logic [7:0]  END_MARKER_RST    = 8'h99;
  localparam logic [15:0] ARM_LIMIT_RST     = 16'd10000;
  localparam logic [15:0] DISARM_LIMIT_RST  = 16'd256;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_ARM_LIMIT    = 2'd2;
  localparam logic [1:0] REG_DISARM_LIMIT = 2'd3;

  // Input item
  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [7:0]  roll_quarter_deg;
    logic signed [7:0]  pitch_quarter_deg;
    logic signed [11:0] yaw_tenth_deg;
    logic [15:0]        thrust_value;
    logic               remote_mode;
    logic               flight_key;
    logic               land_key;
    logic               stop_flag;
    logic               fly_mode_bit;
  } out_item_t;

  // Mode switch and key latches
  typedef struct packed {
    logic mode;
    logic flight;
    logic land;
    logic stop;
  } latch_t;

endpackage
`default_nettype wire

>>> rtl/core/rcfrd_decode.sv
// Frame decoder: scales the stick bytes and updates mode and key latches.
`default_nettype none
module rcfrd_decode (
  input  wire logic [7:0]         roll_b,
  input  wire logic [7:0]         pitch_b,
  input  wire logic [7:0]         thr_b,
  input  wire logic [7:0]         yaw_b,
  input  wire logic [7:0]         cmd_b,
  input  wire logic [15:0]        prev_thrust,
  input  wire logic [15:0]        arm_limit,
  input  wire logic [15:0]        disarm_limit,
  input  wire rcfrd_pkg::latch_t  lat_cur,
  output rcfrd_pkg::latch_t       lat_nxt,
  output rcfrd_pkg::out_item_t    item
);

  logic [15:0] thrust;

  assign thrust = {thr_b, 8'h00};

  // Mode switch, then key latches
  always_comb begin
    lat_nxt = lat_cur;
    if (thrust == rcfrd_pkg::ARM_THRUST && prev_thrust < arm_limit) begin
      lat_nxt.mode   = 1'b1;
      lat_nxt.flight = 1'b0;
      lat_nxt.land   = 1'b0;
    end else if (thrust == 16'h0000 && prev_thrust > disarm_limit) begin
      lat_nxt.mode = 1'b0;
    end
    if (lat_nxt.mode) begin
      if (cmd_b[0]) begin
        lat_nxt.flight = 1'b1;
        lat_nxt.land   = 1'b0;
      end
      if (cmd_b[1]) begin
        lat_nxt.flight = 1'b0;
        lat_nxt.land   = 1'b1;
      end
      if (cmd_b[2]) begin
        lat_nxt.flight = 1'b0;
        lat_nxt.land   = 1'b0;
        lat_nxt.stop   = 1'b1;
      end else begin
        lat_nxt.stop = 1'b0;
      end
    end else begin
      lat_nxt.flight = 1'b0;
      lat_nxt.land   = 1'b0;
    end
  end

  // Result fields: subtracting 128 from a byte flips its top bit
  always_comb begin
    item.roll_quarter_deg  = roll_b ^ rcfrd_pkg::STICK_MID;
    item.pitch_quarter_deg = pitch_b ^ rcfrd_pkg::STICK_MID;
    item.yaw_tenth_deg     = {yaw_b ^ rcfrd_pkg::STICK_MID, 4'h0};
    item.thrust_value      = thrust;
    item.remote_mode       = lat_nxt.mode;
    item.flight_key        = lat_nxt.flight;
    item.land_key          = lat_nxt.land;
    item.stop_flag         = lat_nxt.stop;
    item.fly_mode_bit      = cmd_b[4];
  end

endmodule
`default_nettype wire

>>> rtl/core/rc_frame_receiver_decoder_core.sv
// Top level of the RC frame receiver and decoder.
`default_nettype none
// Takes one received byte or receive-timeout event per item and deframes
// 8-byte frames: start marker, roll, pitch, thrust, yaw, command, XOR checksum
// of the five payload bytes, end marker. Each good frame yields one result
// item once its end-marker byte is accepted; all other items yield none. An
// item is taken every unstalled cycle: the parser state and the output
// register update in the same cycle. in_stall is raised only when a result
// still waits in the output register under out_stall and the offered byte
// would complete another frame. Markers and thrust limits are APB registers
// at byte addresses 0, 4, 8 and 12; write them only while the block is idle.
module rc_frame_receiver_decoder_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire rcfrd_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rcfrd_pkg::out_item_t       out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [3:0]            cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

`include "rc_frame_receiver_decoder_core_assert.svh"

  typedef enum logic [1:0] {PH_HUNT, PH_DATA, PH_CHK, PH_END} phase_t;

  phase_t              phase_r, phase_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic [7:0]          xor_r, xor_nxt;
  logic [7:0]          store_r [0:4];
  logic [15:0]         prev_thrust_r;
  rcfrd_pkg::latch_t   lat_r, lat_dec;
  logic [7:0]          start_marker_r, end_marker_r;
  logic [15:0]         arm_limit_r, disarm_limit_r;
  logic                out_valid_r, out_valid_nxt;
  rcfrd_pkg::out_item_t out_data_r, dec_item;
  logic                in_fire, emit, emit_fire, cfg_wr, store_we;
  logic [1:0]          cfg_idx;

  // Handshake
  assign emit      = (phase_r == PH_END) && !in_data.action &&
                     (in_data.rx_byte == end_marker_r);
  assign in_stall  = out_valid_r && out_stall && emit;
  assign in_fire   = in_valid && !in_stall;
  assign emit_fire = in_fire && emit;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_valid_nxt = emit_fire || (out_valid_r && out_stall);

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      rcfrd_pkg::REG_START_MARKER: cfg_prdata = {24'h0, start_marker_r};
      rcfrd_pkg::REG_END_MARKER:   cfg_prdata = {24'h0, end_marker_r};
      rcfrd_pkg::REG_ARM_LIMIT:    cfg_prdata = {16'h0, arm_limit_r};
      default:                     cfg_prdata = {16'h0, disarm_limit_r};
    endcase
  end

  // Parser next state
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    xor_nxt   = xor_r;
    store_we  = 1'b0;
    if (in_data.action) begin
      phase_nxt = PH_HUNT;
      idx_nxt   = 3'd0;
      xor_nxt   = 8'h00;
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_data.rx_byte == start_marker_r) begin
            idx_nxt   = 3'd0;
            xor_nxt   = 8'h00;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          store_we = (idx_r < rcfrd_pkg::PAYLOAD_LEN);
          xor_nxt  = xor_r ^ in_data.rx_byte;
          idx_nxt  = idx_r + 3'd1;
          if (idx_nxt >= rcfrd_pkg::PAYLOAD_LEN) begin
            phase_nxt = PH_CHK;
          end
        end
        PH_CHK: begin
          phase_nxt = (in_data.rx_byte == xor_r) ? PH_END : PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
          idx_nxt   = 3'd0;
          xor_nxt   = 8'h00;
        end
      endcase
    end
  end

  // Frame decode
  rcfrd_decode u_decode (
    .roll_b       (store_r[0]),
    .pitch_b      (store_r[1]),
    .thr_b        (store_r[2]),
    .yaw_b        (store_r[3]),
    .cmd_b        (store_r[4]),
    .prev_thrust  (prev_thrust_r),
    .arm_limit    (arm_limit_r),
    .disarm_limit (disarm_limit_r),
    .lat_cur      (lat_r),
    .lat_nxt      (lat_dec),
    .item         (dec_item)
  );

  // Control state, configuration and latches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      idx_r          <= 3'd0;
      xor_r          <= 8'h00;
      prev_thrust_r  <= 16'h0000;
      lat_r          <= '0;
      out_valid_r    <= 1'b0;
      start_marker_r <= rcfrd_pkg::START_MARKER_RST;
      end_marker_r   <= rcfrd_pkg::END_MARKER_RST;
      arm_limit_r    <= rcfrd_pkg::ARM_LIMIT_RST;
      disarm_limit_r <= rcfrd_pkg::DISARM_LIMIT_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        xor_r   <= xor_nxt;
      end
      if (emit_fire) begin
        prev_thrust_r <= dec_item.thrust_value;
        lat_r         <= lat_dec;
      end
      if (cfg_wr) begin
        unique case (cfg_idx)
          rcfrd_pkg::REG_START_MARKER: start_marker_r <= cfg_pwdata[7:0];
          rcfrd_pkg::REG_END_MARKER:   end_marker_r   <= cfg_pwdata[7:0];
          rcfrd_pkg::REG_ARM_LIMIT:    arm_limit_r    <= cfg_pwdata[15:0];
          default:                     disarm_limit_r <= cfg_pwdata[15:0];
        endcase
      end
    end
  end

  // Payload bytes and result register
  always_ff @(posedge clk) begin
    if (in_fire && store_we) begin
      store_r[idx_r] <= in_data.rx_byte;
    end
    if (emit_fire) begin
      out_data_r <= dec_item;
    end
  end

  // Checks
  `RCFRD_ASSERT_NEXT(a_emit_gives_result, emit_fire, out_valid_r,
    "good frame did not load the result register")
  `RCFRD_ASSERT_NOW(a_data_index, phase_r == PH_DATA, idx_r < rcfrd_pkg::PAYLOAD_LEN,
    "payload index out of range while collecting payload")
  `RCFRD_ASSERT_NOW(a_chk_index, phase_r == PH_CHK, idx_r == rcfrd_pkg::PAYLOAD_LEN,
    "checksum phase entered before five payload bytes")
  `RCFRD_ASSERT_NOW(a_stop_clears_keys, out_valid_r && out_data_r.stop_flag,
    !out_data_r.flight_key && !out_data_r.land_key,
    "stop flag reported together with a key latch")
  `RCFRD_ASSERT_NEXT(a_timeout_hunts, in_fire && in_data.action,
    phase_r == PH_HUNT && idx_r == 3'd0 && xor_r == 8'h00,
    "timeout did not return the parser to hunting")

endmodule
`default_nettype wire
